@@ rtl/core/crle_pkg.sv @@
package crle_pkg;

    // Default sizing of the node pool
    localparam int CAPACITY_DEF  = 16;
    localparam int DATA_BITS_DEF = 32;

    // Fixed field widths
    localparam int KIND_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = ((KIND_W + VALUE_W + 7) / 8) * 8;

    // Command codes
    typedef enum logic [KIND_W-1:0] {
        KIND_INS_AFTER  = 3'd0,
        KIND_INS_BEFORE = 3'd1,
        KIND_REMOVE     = 3'd2,
        KIND_FORWARD    = 3'd3,
        KIND_BACK       = 3'd4,
        KIND_CLEAR      = 3'd5
    } kind_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Requests from the ring logic to the node allocator
    typedef struct packed {
        logic take;
        logic give;
        logic clear;
    } alloc_ctrl_t;

endpackage

@@ rtl/core/crle_alloc.sv @@
module crle_alloc #(
    parameter int CAPACITY = crle_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  crle_pkg::alloc_ctrl_t         ctrl,
    input  logic [$clog2(CAPACITY)-1:0]   give_slot,
    output logic                          avail,
    output logic [$clog2(CAPACITY)-1:0]   take_slot
);

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

    logic [SLOT_W-1:0]  stack_reg [CAPACITY];
    logic [COUNT_W-1:0] depth_reg, depth_next;
    logic [COUNT_W-1:0] mark_reg, mark_next;
    logic [COUNT_W-1:0] depth_dec;
    logic               have_freed;

    // Freed nodes first, then never-used ones in order
    assign have_freed = (depth_reg != '0);
    assign depth_dec  = depth_reg - COUNT_W'(1);
    assign avail      = have_freed || (mark_reg < CAP_C);
    assign take_slot  = have_freed ? stack_reg[depth_dec[SLOT_W-1:0]]
                                   : mark_reg[SLOT_W-1:0];

    // Stack depth and fresh mark
    always_comb begin
        depth_next = depth_reg;
        mark_next  = mark_reg;
        if (ctrl.clear) begin
            depth_next = '0;
            mark_next  = '0;
        end else if (ctrl.take) begin
            if (have_freed) begin
                depth_next = depth_dec;
            end else begin
                mark_next = mark_reg + COUNT_W'(1);
            end
        end else if (ctrl.give && (depth_reg < CAP_C)) begin
            depth_next = depth_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            mark_reg  <= '0;
        end else begin
            depth_reg <= depth_next;
            mark_reg  <= mark_next;
        end
    end

    // Push of a freed slot
    always_ff @(posedge aclk) begin
        if (ctrl.give && !ctrl.clear && (depth_reg < CAP_C)) begin
            stack_reg[depth_reg[SLOT_W-1:0]] <= give_slot;
        end
    end

endmodule

@@ rtl/core/crle_ring.sv @@
module crle_ring #(
    parameter int CAPACITY  = crle_pkg::CAPACITY_DEF,
    parameter int DATA_BITS = crle_pkg::DATA_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              fire,
    input  crle_pkg::kind_t                   kind,
    input  logic [crle_pkg::VALUE_W-1:0]      value,
    output crle_pkg::alloc_ctrl_t             alloc_ctrl,
    output logic [$clog2(CAPACITY)-1:0]       give_slot,
    input  logic                              alloc_avail,
    input  logic [$clog2(CAPACITY)-1:0]       alloc_slot,
    output crle_pkg::status_t                 status,
    output logic [crle_pkg::VALUE_W-1:0]      removed_value,
    output logic [crle_pkg::VALUE_W-1:0]      cursor_value,
    output logic [$clog2(CAPACITY + 1)-1:0]   entry_count
);

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int VW      = crle_pkg::VALUE_W;
    localparam int WIDE_W  = (DATA_BITS > VW) ? DATA_BITS : VW;

    // Node pool, left unreset: links only ever reach written nodes
    logic [DATA_BITS-1:0] data_reg [CAPACITY];
    logic [SLOT_W-1:0]    fwd_reg  [CAPACITY];
    logic [SLOT_W-1:0]    bwd_reg  [CAPACITY];

    logic [SLOT_W-1:0]  cursor_reg, cursor_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [SLOT_W-1:0]    cur_fw, cur_bw;
    logic                 empty;
    logic [WIDE_W-1:0]    value_wide;
    logic [DATA_BITS-1:0] value_store;
    logic [WIDE_W-1:0]    store_wide;
    logic [WIDE_W-1:0]    rm_wide, cv_wide;

    // Link and node writes of one command
    logic                 fwd_we, bwd_we, new_we, new_cursor;
    logic [SLOT_W-1:0]    fwd_idx, fwd_val, bwd_idx, bwd_val;
    logic [SLOT_W-1:0]    new_fw, new_bw;

    assign cur_fw      = fwd_reg[cursor_reg];
    assign cur_bw      = bwd_reg[cursor_reg];
    assign empty       = (count_reg == '0);
    assign value_wide  = WIDE_W'(value);
    assign value_store = value_wide[DATA_BITS-1:0];
    assign store_wide  = WIDE_W'(value_store);
    assign give_slot   = cursor_reg;

    // Command decode and next state
    always_comb begin
        status      = crle_pkg::STATUS_OK;
        alloc_ctrl  = '0;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        fwd_we      = 1'b0;
        bwd_we      = 1'b0;
        new_we      = 1'b0;
        new_cursor  = 1'b0;
        fwd_idx     = cursor_reg;
        fwd_val     = alloc_slot;
        bwd_idx     = cursor_reg;
        bwd_val     = alloc_slot;
        new_fw      = alloc_slot;
        new_bw      = alloc_slot;
        case (kind)
            crle_pkg::KIND_INS_AFTER,
            crle_pkg::KIND_INS_BEFORE: begin
                if (!alloc_avail) begin
                    status = crle_pkg::STATUS_FULL;
                end else begin
                    alloc_ctrl.take = fire;
                    new_we          = 1'b1;
                    count_next      = count_reg + COUNT_W'(1);
                    if (empty) begin
                        new_cursor  = 1'b1;
                        cursor_next = alloc_slot;
                    end else if (kind == crle_pkg::KIND_INS_AFTER) begin
                        new_fw  = cur_fw;
                        new_bw  = cursor_reg;
                        fwd_we  = 1'b1;
                        fwd_idx = cursor_reg;
                        bwd_we  = 1'b1;
                        bwd_idx = cur_fw;
                    end else begin
                        new_fw  = cursor_reg;
                        new_bw  = cur_bw;
                        fwd_we  = 1'b1;
                        fwd_idx = cur_bw;
                        bwd_we  = 1'b1;
                        bwd_idx = cursor_reg;
                    end
                end
            end
            crle_pkg::KIND_REMOVE: begin
                if (empty) begin
                    status = crle_pkg::STATUS_EMPTY;
                end else begin
                    alloc_ctrl.give = fire;
                    count_next      = count_reg - COUNT_W'(1);
                    if (count_reg == COUNT_W'(1)) begin
                        cursor_next = '0;
                    end else begin
                        fwd_we      = 1'b1;
                        fwd_idx     = cur_bw;
                        fwd_val     = cur_fw;
                        bwd_we      = 1'b1;
                        bwd_idx     = cur_fw;
                        bwd_val     = cur_bw;
                        cursor_next = cur_fw;
                    end
                end
            end
            crle_pkg::KIND_FORWARD: begin
                if (empty) begin
                    status = crle_pkg::STATUS_EMPTY;
                end else begin
                    cursor_next = cur_fw;
                end
            end
            crle_pkg::KIND_BACK: begin
                if (empty) begin
                    status = crle_pkg::STATUS_EMPTY;
                end else begin
                    cursor_next = cur_bw;
                end
            end
            crle_pkg::KIND_CLEAR: begin
                alloc_ctrl.clear = fire;
                cursor_next      = '0;
                count_next       = '0;
            end
            default: begin
            end
        endcase
    end

    // Result fields; a fresh cursor node shows the value as it will be stored
    always_comb begin
        rm_wide = WIDE_W'(data_reg[cursor_reg]);
        cv_wide = WIDE_W'(data_reg[cursor_next]);
        removed_value = '0;
        if ((kind == crle_pkg::KIND_REMOVE) && !empty) begin
            removed_value = rm_wide[VW-1:0];
        end
        if (count_next == '0) begin
            cursor_value = '0;
        end else if (new_cursor) begin
            cursor_value = store_wide[VW-1:0];
        end else begin
            cursor_value = cv_wide[VW-1:0];
        end
    end

    assign entry_count = count_next;

    // Cursor and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
            count_reg  <= '0;
        end else if (fire) begin
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
        end
    end

    // Node pool writes
    always_ff @(posedge aclk) begin
        if (fire) begin
            if (fwd_we) begin
                fwd_reg[fwd_idx] <= fwd_val;
            end
            if (bwd_we) begin
                bwd_reg[bwd_idx] <= bwd_val;
            end
            if (new_we) begin
                data_reg[alloc_slot] <= value_store;
                fwd_reg[alloc_slot]  <= new_fw;
                bwd_reg[alloc_slot]  <= new_bw;
            end
        end
    end

endmodule

@@ rtl/core/cursor_ring_list_engine_unit.sv @@
// Cursor ring list engine: a circular doubly linked ring of values with a
// cursor, held in a pool of CAPACITY nodes.
// Input channel (s_): one command beat per item, the kind (insert after,
// insert before, remove, forward, back, clear) and the value to insert.
// Result channel (m_): one beat per command carrying status, the removed
// value, the value now at the cursor and the number of values in the ring.
// Each command is decoded and applied against the node pool as it is taken;
// its result sits in the output register from the next cycle on, and one
// command is taken every cycle while s_tready is high.
// The output register parts the two sides: a new command is taken while a
// result is being handed over, and s_tready drops only while an untaken
// result waits with m_tready low. Nothing is lost while the receiver stalls.
// Reset (aresetn low at a clock edge) empties the ring, resets the node
// allocator and drops any pending result; no clearing pass follows, the
// block takes commands in the first cycle after reset.
module cursor_ring_list_engine_unit #(
    parameter int CAPACITY  = crle_pkg::CAPACITY_DEF,
    parameter int DATA_BITS = crle_pkg::DATA_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // kind[2:0], value[34:3], zero pad
    input  logic [crle_pkg::S_TDATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // status[1:0], removed_value[33:2], cursor_value[65:34], entry_count, pad
    output logic [((2 * crle_pkg::VALUE_W + crle_pkg::STATUS_W
                    + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int VW      = crle_pkg::VALUE_W;
    localparam int KW      = crle_pkg::KIND_W;
    localparam int RES_W   = 2 * VW + crle_pkg::STATUS_W + COUNT_W;
    localparam int M_W     = ((RES_W + 7) / 8) * 8;

    logic                        fire;
    crle_pkg::kind_t             kind;
    logic [VW-1:0]               value;
    crle_pkg::alloc_ctrl_t       alloc_ctrl;
    logic [SLOT_W-1:0]           give_slot, alloc_slot;
    logic                        alloc_avail;
    crle_pkg::status_t           status;
    logic [VW-1:0]               removed_value, cursor_value;
    logic [COUNT_W-1:0]          entry_count;
    logic                        out_valid_reg;
    logic [M_W-1:0]              out_data_reg;

    // Beat handshake
    assign s_tready = !out_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;
    assign kind     = crle_pkg::kind_t'(s_tdata[KW-1:0]);
    assign value    = s_tdata[KW+VW-1:KW];

    crle_ring #(
        .CAPACITY  (CAPACITY),
        .DATA_BITS (DATA_BITS)
    ) u_ring (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .kind          (kind),
        .value         (value),
        .alloc_ctrl    (alloc_ctrl),
        .give_slot     (give_slot),
        .alloc_avail   (alloc_avail),
        .alloc_slot    (alloc_slot),
        .status        (status),
        .removed_value (removed_value),
        .cursor_value  (cursor_value),
        .entry_count   (entry_count)
    );

    crle_alloc #(
        .CAPACITY (CAPACITY)
    ) u_alloc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (alloc_ctrl),
        .give_slot (give_slot),
        .avail     (alloc_avail),
        .take_slot (alloc_slot)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= M_W'({entry_count, cursor_value, removed_value, status});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import crle_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int COUNT_W    = $clog2(CAP + 1);
    localparam int M_TDATA_W  = ((2 * VALUE_W + STATUS_W + COUNT_W + 7) / 8) * 8;
    localparam int SLOT_W     = $clog2(CAP);
    localparam int ITEMS      = 1300;
    localparam int IDLE_PCT   = 23;

    // Kind codes the block treats as no-ops
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    // What one command should report
    typedef struct {
        status_t             status;
        logic [VALUE_W-1:0]  removed;
        logic [VALUE_W-1:0]  at_cursor;
        logic [COUNT_W-1:0]  count;
    } ring_view_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // kind[2:0], value[34:3], zero pad
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // status[1:0], removed[33:2], cursor[65:34], count[70:66]

    cursor_ring_list_engine_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the ring
    logic [VALUE_W-1:0] node_val   [CAP] = '{default: '0};
    logic [SLOT_W-1:0]  link_next  [CAP] = '{default: '0};
    logic [SLOT_W-1:0]  link_prev  [CAP] = '{default: '0};
    logic [SLOT_W-1:0]  spare_slots[CAP] = '{default: '0};
    logic [SLOT_W-1:0]  cur_pos     = '0;
    int                 ring_size   = 0;
    int                 spare_top   = 0;
    int                 unused_base = 0;

    ring_view_t ring_views[$];

    int  failures     = 0;
    int  beats_sent   = 0;
    int  beats_seen   = 0;
    int  n_rejected   = 0;
    int  n_empty_hits = 0;
    int  peak_size    = 0;
    bit  steady       = 1'b0;

    // Receiver hold requests: written at rising edges, taken up at falling ones
    int  hold_len = 0;
    int  hold_seq = 0;
    int  hold_seen = 0;
    int  hold_left = 0;

    // Clock, 4 ns period
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Apply one command to the shadow ring and return the expected report
    function automatic ring_view_t apply_ring_command(input logic [KIND_W-1:0] k,
                                                      input logic [VALUE_W-1:0] v);
        ring_view_t        r;
        logic [SLOT_W-1:0] c, n, nb, fw, bw;
        logic              got;
        r.status  = STATUS_OK;
        r.removed = '0;
        c = cur_pos;
        case (k)
            KIND_INS_AFTER, KIND_INS_BEFORE: begin
                // free stack first, then never-used slots
                got = 1'b1;
                n   = '0;
                if (spare_top > 0) begin
                    spare_top--;
                    n = spare_slots[spare_top];
                end else if (unused_base < CAP) begin
                    n = unused_base[SLOT_W-1:0];
                    unused_base++;
                end else begin
                    got = 1'b0;
                end
                if (!got) begin
                    r.status = STATUS_FULL;
                end else begin
                    node_val[n] = v;
                    if (ring_size == 0) begin
                        link_next[n] = n;
                        link_prev[n] = n;
                        cur_pos      = n;
                    end else if (k == KIND_INS_AFTER) begin
                        nb            = link_next[c];
                        link_next[n]  = nb;
                        link_prev[n]  = c;
                        link_prev[nb] = n;
                        link_next[c]  = n;
                    end else begin
                        nb            = link_prev[c];
                        link_next[n]  = c;
                        link_prev[n]  = nb;
                        link_next[nb] = n;
                        link_prev[c]  = n;
                    end
                    ring_size++;
                end
            end
            KIND_REMOVE: begin
                if (ring_size == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.removed = node_val[c];
                    if (ring_size == 1) begin
                        cur_pos = '0;
                    end else begin
                        fw            = link_next[c];
                        bw            = link_prev[c];
                        link_next[bw] = fw;
                        link_prev[fw] = bw;
                        cur_pos       = fw;
                    end
                    if (spare_top < CAP) begin
                        spare_slots[spare_top] = c;
                        spare_top++;
                    end
                    ring_size--;
                end
            end
            KIND_FORWARD, KIND_BACK: begin
                if (ring_size == 0)
                    r.status = STATUS_EMPTY;
                else
                    cur_pos = (k == KIND_FORWARD) ? link_next[c] : link_prev[c];
            end
            KIND_CLEAR: begin
                cur_pos     = '0;
                ring_size   = 0;
                spare_top   = 0;
                unused_base = 0;
            end
            default: ;
        endcase
        r.at_cursor = (ring_size == 0) ? '0 : node_val[cur_pos];
        r.count     = ring_size[COUNT_W-1:0];
        return r;
    endfunction

    // Value source: mostly random, a quarter of the time an extreme
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Offer one command beat; called and left at a falling edge
    task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v);
        ring_view_t r;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - KIND_W - VALUE_W){1'b0}}, v, k};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        r = apply_ring_command(k, v);
        ring_views.push_back(r);
        beats_sent++;
        if (r.status == STATUS_FULL)
            n_rejected++;
        if (r.status == STATUS_EMPTY)
            n_empty_hits++;
        if (ring_size > peak_size)
            peak_size = ring_size;
        @(negedge aclk);
    endtask

    // Random command with the given insert, remove and clear weights (percent)
    task automatic send_random(input int ins_pct, input int rem_pct, input int clr_pct);
        int            roll;
        logic [KIND_W-1:0] k;
        roll = $urandom_range(99);
        if (roll < ins_pct)
            k = $urandom_range(1) ? KIND_INS_AFTER : KIND_INS_BEFORE;
        else if (roll < ins_pct + rem_pct)
            k = KIND_REMOVE;
        else if (roll < ins_pct + rem_pct + clr_pct)
            k = KIND_CLEAR;
        else if (roll < ins_pct + rem_pct + clr_pct + 2)
            k = $urandom_range(1) ? KIND_SPARE_6 : KIND_SPARE_7;
        else
            k = $urandom_range(1) ? KIND_FORWARD : KIND_BACK;
        send_cmd(k, pick_value());
    endtask

    // Result checker
    always @(posedge aclk) begin : check_results
        ring_view_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (ring_views.size() == 0) begin
                $error("unexpected result beat: %h", m_tdata);
                failures++;
            end else begin
                want = ring_views.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                    failures++;
                end
                if (m_tdata[33:2] !== want.removed) begin
                    $error("removed_value: expected %0d, got %0d",
                           $signed(want.removed), $signed(m_tdata[33:2]));
                    failures++;
                end
                if (m_tdata[65:34] !== want.at_cursor) begin
                    $error("cursor_value: expected %0d, got %0d",
                           $signed(want.at_cursor), $signed(m_tdata[65:34]));
                    failures++;
                end
                if (m_tdata[66 +: COUNT_W] !== want.count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.count, m_tdata[66 +: COUNT_W]);
                    failures++;
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold when one is requested
    always @(negedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Operations on an empty ring, spare kinds and clear
    task automatic test_empty_ring();
        send_cmd(KIND_REMOVE, pick_value());
        send_cmd(KIND_FORWARD, pick_value());
        send_cmd(KIND_BACK, pick_value());
        send_cmd(KIND_SPARE_6, 32'hFFFF_FFFF);
        send_cmd(KIND_SPARE_7, 32'h0000_0000);
        send_cmd(KIND_CLEAR, pick_value());
    endtask

    // Fill the pool, overflow it, reuse a freed node, then clear
    task automatic test_fill_to_capacity();
        logic [VALUE_W-1:0] extremes [4] = '{32'h8000_0000, 32'h7FFF_FFFF,
                                             32'h0000_0000, 32'hFFFF_FFFF};
        for (int i = 0; i < CAP; i++)
            send_cmd(i[0] ? KIND_INS_BEFORE : KIND_INS_AFTER,
                     (i < 4) ? extremes[i] : $urandom());
        send_cmd(KIND_INS_AFTER, pick_value());
        send_cmd(KIND_INS_BEFORE, pick_value());
        send_cmd(KIND_REMOVE, pick_value());
        send_cmd(KIND_INS_BEFORE, 32'hA5A5_5A5A);
        send_cmd(KIND_BACK, pick_value());
        send_cmd(KIND_CLEAR, pick_value());
    endtask

    // Receiver holds off for a long stretch while commands keep coming
    task automatic test_output_stall();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        hold_len <= 300;
        hold_seq <= hold_seq + 1;
        @(negedge aclk);
        steady = 1'b1;
        for (int i = 0; i < 40; i++)
            send_random(50, 25, 2);
        steady = 1'b0;
    endtask

    // Random traffic in phases: growth, a steady stretch, draining, churn
    task automatic test_random_traffic();
        for (int i = 0; i < ITEMS; i++) begin
            steady = (i >= 400 && i < 650);
            if (i < 400)
                send_random(55, 15, 1);
            else if (i < 650)
                send_random(35, 30, 2);
            else if (i < 1000)
                send_random(20, 45, 1);
            else
                send_random(40, 35, 5);
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        test_empty_ring();
        test_fill_to_capacity();
        test_output_stall();
        test_random_traffic();
        s_tvalid <= 1'b0;

        while (ring_views.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d command beats, checked %0d results; peak ring size %0d of %0d.",
                 beats_sent, beats_seen, peak_size, CAP);
        $display("Full-pool rejects %0d, empty-ring replies %0d, one long output stall.",
                 n_rejected, n_empty_hits);
        if (failures == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
